// File: hdl/raster_line_rle_decoder_defines.svh
// ----------------------------------------------------------------------------
// Raster line RLE decoder assertion macros
// Shared wrappers for the concurrent checks of the decoder.
// ----------------------------------------------------------------------------
`ifndef RASTER_LINE_RLE_DECODER_DEFINES_SVH
`define RASTER_LINE_RLE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rld_pkg.sv
// ----------------------------------------------------------------------------
// Raster line RLE decoder package
// Constants, codes and shared types of the decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

  localparam int BYTES_PER_PIXEL = 3;
  localparam int MAX_WIDTH       = 16383;

  localparam int BYTE_W    = 8;
  localparam int PIXEL_W   = 24;
  localparam int PARTIAL_W = PIXEL_W - BYTE_W;
  localparam int WIDTH_W   = 14;
  localparam int COUNT_W   = 8;
  localparam int LEN_W     = COUNT_W + 1;
  localparam int BIP_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [BYTE_W-1:0] CODE_FILL     = 8'h80;
  localparam logic [BYTE_W-1:0] CODE_REP_MAX  = 8'h7f;
  localparam logic [LEN_W-1:0]  LITERAL_BASE  = 9'd256;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 14'd2480;
  localparam logic [PIXEL_W-1:0] FILL_RESET   = 24'hffffff;
  localparam logic [WIDTH_W-1:0] WIDTH_LIMIT  = WIDTH_W'(MAX_WIDTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOUR = 1'b1;

  typedef enum logic [2:0] {
    PH_REPEAT = 3'b001,
    PH_CODE   = 3'b010,
    PH_PIXEL  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] line_width;
    logic [PIXEL_W-1:0] fill_colour;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] colour;
    logic [WIDTH_W-1:0] run_length;
    logic [BYTE_W-1:0]  row_repeat;
    logic               end_of_line;
    logic               overrun;
  } result_t;

endpackage

// File: hdl/raster_line_rle_decoder.sv
// ----------------------------------------------------------------------------
// Raster line RLE decoder
// Decodes a PackBits-style raster byte stream into colour runs per line.
// ----------------------------------------------------------------------------
// The decoder takes at most one byte per clock and produces at most one run
// beat per byte. Each byte is parsed in the same cycle it is accepted; its run,
// if any, is output from a result register in the next cycle, so data_ready
// stays high while that register is empty or being drained, and throughput is
// one byte per cycle while run_ready is high. Configuration writes are always
// taken; a new line width applies from the next line-repeat byte.
`include "raster_line_rle_decoder_defines.svh"

module raster_line_rle_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rld_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           data_valid,
  output logic                           data_ready,
  input  logic [rld_pkg::BYTE_W-1:0]     data_byte,
  output logic                           run_valid,
  input  logic                           run_ready,
  output logic [rld_pkg::PIXEL_W-1:0]    colour,
  output logic [rld_pkg::WIDTH_W-1:0]    run_length,
  output logic [rld_pkg::BYTE_W-1:0]     row_repeat,
  output logic                           end_of_line,
  output logic                           overrun
);

  rld_pkg::cfg_t    cfg;
  rld_pkg::result_t res_d;
  rld_pkg::result_t res_q;
  logic             res_valid;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign accept    = data_valid && data_ready;

  rld_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rld_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res_d)
  );

  rld_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .res_in    (res_d),
    .run_ready (run_ready),
    .run_valid (run_valid),
    .res_out   (res_q),
    .free      (data_ready)
  );

  assign colour      = res_q.colour;
  assign run_length  = res_q.run_length;
  assign row_repeat  = res_q.row_repeat;
  assign end_of_line = res_q.end_of_line;
  assign overrun     = res_q.overrun;

  `RLD_ASSERT_NOW(a_ovr_eol, clk, rst, run_valid && overrun, end_of_line, "overrun without eol")
  `RLD_ASSERT_NOW(a_len_nz, clk, rst, run_valid, run_length != '0, "zero-length run")
  `RLD_ASSERT_NOW(a_ready_empty, clk, rst, !run_valid, data_ready, "input stalled while empty")
  `RLD_ASSERT_NEXT(a_beat_lands, clk, rst, accept && res_valid, run_valid, "run result was lost")

endmodule

// File: hdl/rld_cfg.sv
// ----------------------------------------------------------------------------
// Raster line RLE decoder configuration registers
// Holds the line width and the fill colour written over the config channel.
// ----------------------------------------------------------------------------
module rld_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [rld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rld_pkg::CFG_DATA_W-1:0] cfg_data,
  output rld_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width  <= rld_pkg::WIDTH_RESET;
      cfg.fill_colour <= rld_pkg::FILL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rld_pkg::REG_LINE_WIDTH: begin
          cfg.line_width <= cfg_data[rld_pkg::WIDTH_W-1:0];
        end
        rld_pkg::REG_FILL_COLOUR: begin
          cfg.fill_colour <= cfg_data[rld_pkg::PIXEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hdl/rld_decode.sv
// ----------------------------------------------------------------------------
// Raster line RLE decoder byte parser
// Per-byte state update of the run decoder and formation of one run result.
// ----------------------------------------------------------------------------
module rld_decode (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [rld_pkg::BYTE_W-1:0] data_byte,
  input  rld_pkg::cfg_t              cfg,
  output logic                       res_valid,
  output rld_pkg::result_t           res
);

  rld_pkg::phase_t                phase, phase_next;
  logic [rld_pkg::BIP_W-1:0]      byte_in_pixel, byte_in_pixel_next;
  logic [rld_pkg::PARTIAL_W-1:0]  partial_pixel, partial_pixel_next;
  logic                           is_repeat_run, is_repeat_run_next;
  logic [rld_pkg::COUNT_W-1:0]    run_count, run_count_next;
  logic [rld_pkg::WIDTH_W-1:0]    pixels_left, pixels_left_next;
  logic [rld_pkg::BYTE_W-1:0]     row_repeat_count, row_repeat_count_next;

  logic [rld_pkg::PIXEL_W-1:0]    colour;
  logic [rld_pkg::LEN_W-1:0]      len;
  logic [rld_pkg::WIDTH_W-1:0]    len_wide;
  logic [rld_pkg::WIDTH_W-1:0]    width_sat;
  logic                           more;
  logic                           last_byte;

  assign colour    = {partial_pixel, data_byte};
  assign last_byte = !(({1'b0, byte_in_pixel} + 3'd1) < 3'(rld_pkg::BYTES_PER_PIXEL));
  assign more      = !is_repeat_run && (run_count != '0);
  assign len       = is_repeat_run ? ({1'b0, run_count} + rld_pkg::LEN_W'(1))
                                   : rld_pkg::LEN_W'(1);
  assign len_wide  = rld_pkg::WIDTH_W'(len);
  assign width_sat = (cfg.line_width > rld_pkg::WIDTH_LIMIT) ? rld_pkg::WIDTH_LIMIT
                                                             : cfg.line_width;

  always_comb begin
    phase_next            = phase;
    byte_in_pixel_next    = byte_in_pixel;
    partial_pixel_next    = partial_pixel;
    is_repeat_run_next    = is_repeat_run;
    run_count_next        = run_count;
    pixels_left_next      = pixels_left;
    row_repeat_count_next = row_repeat_count;
    res_valid             = 1'b0;
    res.colour            = colour;
    res.run_length        = pixels_left;
    res.row_repeat        = row_repeat_count;
    res.end_of_line       = 1'b0;
    res.overrun           = 1'b0;

    unique case (phase)
      rld_pkg::PH_CODE: begin
        if (data_byte == rld_pkg::CODE_FILL) begin
          res_valid        = 1'b1;
          res.colour       = cfg.fill_colour;
          res.end_of_line  = 1'b1;
          pixels_left_next = '0;
          phase_next       = rld_pkg::PH_REPEAT;
        end else begin
          is_repeat_run_next = (data_byte <= rld_pkg::CODE_REP_MAX);
          // A literal code counts the pixels that follow the first one.
          run_count_next     = (data_byte <= rld_pkg::CODE_REP_MAX) ? data_byte
              : rld_pkg::COUNT_W'(rld_pkg::LITERAL_BASE - {1'b0, data_byte});
          byte_in_pixel_next = '0;
          partial_pixel_next = '0;
          phase_next         = rld_pkg::PH_PIXEL;
        end
      end
      rld_pkg::PH_PIXEL: begin
        if (!last_byte) begin
          partial_pixel_next = colour[rld_pkg::PARTIAL_W-1:0];
          byte_in_pixel_next = byte_in_pixel + rld_pkg::BIP_W'(1);
        end else begin
          byte_in_pixel_next = '0;
          partial_pixel_next = '0;
          if (more) begin
            run_count_next = run_count - rld_pkg::COUNT_W'(1);
          end
          if (pixels_left == '0) begin
            // Tail of a literal run beyond the line end is dropped.
            phase_next = more ? rld_pkg::PH_PIXEL : rld_pkg::PH_REPEAT;
          end else begin
            res_valid = 1'b1;
            if (len_wide >= pixels_left) begin
              res.run_length   = pixels_left;
              res.end_of_line  = 1'b1;
              res.overrun      = (len_wide > pixels_left) || more;
              pixels_left_next = '0;
              phase_next       = more ? rld_pkg::PH_PIXEL : rld_pkg::PH_REPEAT;
            end else begin
              res.run_length   = len_wide;
              pixels_left_next = pixels_left - len_wide;
              phase_next       = more ? rld_pkg::PH_PIXEL : rld_pkg::PH_CODE;
            end
          end
        end
      end
      default: begin
        row_repeat_count_next = data_byte;
        pixels_left_next      = width_sat;
        byte_in_pixel_next    = '0;
        partial_pixel_next    = '0;
        phase_next = (width_sat == '0) ? rld_pkg::PH_REPEAT : rld_pkg::PH_CODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= rld_pkg::PH_REPEAT;
      byte_in_pixel    <= '0;
      partial_pixel    <= '0;
      is_repeat_run    <= 1'b0;
      run_count        <= '0;
      pixels_left      <= '0;
      row_repeat_count <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      byte_in_pixel    <= byte_in_pixel_next;
      partial_pixel    <= partial_pixel_next;
      is_repeat_run    <= is_repeat_run_next;
      run_count        <= run_count_next;
      pixels_left      <= pixels_left_next;
      row_repeat_count <= row_repeat_count_next;
    end
  end

endmodule

// File: hdl/rld_out_reg.sv
// ----------------------------------------------------------------------------
// Raster line RLE decoder result register
// Holds one run result until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module rld_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rld_pkg::result_t res_in,
  input  logic             run_ready,
  output logic             run_valid,
  output rld_pkg::result_t res_out,
  output logic             free
);

  // The register can take a new result whenever it is empty or being drained.
  assign free = !run_valid || run_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
    end else if (free) begin
      run_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_out <= res_in;
    end
  end

endmodule
